// ===== hw/rtl/gpu_mmio_register_file_defines.svh =====
// ----------------------------------------------------------------------------
// GPU MMIO register file assertion macros
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GPU_MMIO_REGISTER_FILE_DEFINES_SVH
`define GPU_MMIO_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication.
`define GMRF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmrf assertion failed");

// Next-cycle implication.
`define GMRF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmrf assertion failed");

`endif

// ===== hw/rtl/gmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// GPU MMIO register file package
// Access kinds, register word indexes, status bits and reset defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmrf_pkg;

    typedef logic [12:0] reg_idx_t;
    typedef logic [31:0] word_t;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_REINIT = 2'd2;

    localparam reg_idx_t R_CONFIG_CNTL   = 13'h0038;
    localparam reg_idx_t R_RBBM_CNTL     = 13'h003B;
    localparam reg_idx_t R_SOFT_RESET    = 13'h003C;
    localparam reg_idx_t R_INT_STATUS    = 13'h01F3;
    localparam reg_idx_t R_INT_ACK       = 13'h01F4;
    localparam reg_idx_t R_ME_STATUS     = 13'h01F7;
    localparam reg_idx_t R_ME_WADDR      = 13'h01F8;
    localparam reg_idx_t R_ME_RADDR      = 13'h01F9;
    localparam reg_idx_t R_ME_DATA       = 13'h01FA;
    localparam reg_idx_t R_DEBUG         = 13'h039B;
    localparam reg_idx_t R_PFP_ADDR      = 13'h045F;
    localparam reg_idx_t R_PFP_DATA      = 13'h0460;
    localparam reg_idx_t R_BUS_STATUS    = 13'h05D0;
    localparam reg_idx_t R_MH_STATUS     = 13'h0A07;
    localparam reg_idx_t R_COHER_STATUS  = 13'h0A31;
    localparam reg_idx_t R_EDRAM_TIMING  = 13'h0F00;
    localparam reg_idx_t R_CRTC_CONTROL  = 13'h180A;
    localparam reg_idx_t R_LUT_AUTOFILL  = 13'h1928;
    localparam reg_idx_t R_V_COUNTER     = 13'h194C;
    localparam reg_idx_t R_VBLANK_STATUS = 13'h194D;
    localparam reg_idx_t R_VLINE_STATUS  = 13'h1951;
    localparam reg_idx_t R_VIEWPORT      = 13'h1961;
    localparam reg_idx_t R_ANA_ADDR      = 13'h1E54;
    localparam reg_idx_t R_ANA_DATA      = 13'h1E55;
    localparam reg_idx_t R_SPLL          = 13'h0084;
    localparam reg_idx_t R_RPLL          = 13'h0091;
    localparam reg_idx_t R_FPLL          = 13'h0099;
    localparam reg_idx_t R_MPLL          = 13'h00A1;
    localparam reg_idx_t R_MDLL1         = 13'h00A3;

    localparam word_t MH_READY       = 32'h0200_0000;
    localparam word_t MH_VSYNC       = 32'h0000_0002;
    localparam word_t COHER_BUSY     = 32'h8000_0000;
    localparam word_t BUS_SET        = 32'h0000_0400;
    localparam word_t BUS_CLR        = 32'h0000_0080;
    localparam word_t EDRAM_BITS     = 32'h0006_0000;
    localparam word_t EDRAM_LIMIT    = 32'h0000_0400;
    localparam word_t TRIG_LOW       = 32'h0000_0001;
    localparam word_t TRIG_HIGH      = 32'h0100_0000;
    localparam word_t TRIG_DONE      = 32'h0000_0002;
    localparam word_t CRTC_VSYNC_EN  = 32'h0100_0000;
    localparam word_t CONFIG_DEFAULT = 32'h1000_0000;
    localparam word_t BUS_DEFAULT    = 32'h0000_0600;
    localparam word_t VBLANK_ACTIVE  = 32'h0000_FFFF;
    localparam word_t PLL_DEFAULT    = 32'h1910_0000;

    localparam int unsigned FRAME_US  = 16667;
    localparam int unsigned VBLANK_US = 500;
    localparam logic [2:0]  REV_RESET = 3'd5;
    localparam logic [2:0]  REV_DLL   = 3'd4;

    function automatic word_t seed_value(input reg_idx_t a, input logic [2:0] rev);
        word_t v;
        v = '0;
        unique case (a)
            R_CONFIG_CNTL:   v = CONFIG_DEFAULT;
            R_DEBUG:         v = 32'h000F_0000;
            R_BUS_STATUS:    v = BUS_DEFAULT;
            R_MH_STATUS:     v = MH_READY;
            R_COHER_STATUS:  v = COHER_BUSY;
            R_V_COUNTER:     v = 32'd720;
            R_VLINE_STATUS:  v = 32'd1;
            R_VIEWPORT:      v = 32'h0500_02D0;
            R_EDRAM_TIMING:  v = EDRAM_BITS;
            R_SPLL:          v = 32'h0900_0000;
            R_RPLL:          v = 32'h1100_0C00;
            R_FPLL:          v = 32'h1A00_0001;
            R_MPLL:          v = PLL_DEFAULT;
            R_MDLL1:         v = (rev >= REV_DLL) ? PLL_DEFAULT : '0;
            default:         v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpu_mmio_register_file.sv =====
// ----------------------------------------------------------------------------
// GPU MMIO register file
// Register words and two microcode RAMs in synchronous memories, with a
// sequencer for read side effects, write side effects and reinitialize.
// ----------------------------------------------------------------------------
// Usage: an item (kind, reg_index, write_data, time_us) is accepted when
// in_valid is high and in_stall is low. Only reads produce a result item,
// read_data, on out_valid/out_stall. Accesses are handled one at a time.
// A plain read passes through S_EXEC and S_RESP, and its result is registered
// onto out_valid as it leaves S_RESP; the next item is accepted in S_IDLE. A
// write passes through S_EXEC, then S_MOD or S_C1 and S_C2 when it updates
// further registers. Writes to the microcode pointer registers and reads of
// vblank status pass through a multiply-based remainder unit (S_DIV).
// Reinitialize sweeps all three memories one word per cycle, across the
// largest of the three depths, seeding the defaults as it goes. The same
// sweep runs after reset, during which in_stall is high; configuration
// writes are taken at any time. While out_stall holds a result, the output
// register keeps it and the next read waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gpu_mmio_register_file_defines.svh"

module gpu_mmio_register_file #(
    parameter int unsigned REG_WORDS            = 8192,
    parameter int unsigned ENGINE_UCODE_WORDS   = 1024,
    parameter int unsigned PREFETCH_UCODE_WORDS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [12:0] reg_index,
    input  wire logic [31:0] write_data,
    input  wire logic [62:0] time_us,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data
);

    localparam int unsigned AW    = $clog2(REG_WORDS);
    localparam int unsigned EPW   = $clog2(ENGINE_UCODE_WORDS);
    localparam int unsigned PPW   = $clog2(PREFETCH_UCODE_WORDS);
    localparam int unsigned MAXUC = (ENGINE_UCODE_WORDS > PREFETCH_UCODE_WORDS)
                                    ? ENGINE_UCODE_WORDS : PREFETCH_UCODE_WORDS;
    localparam int unsigned CLR_N = (REG_WORDS > MAXUC) ? REG_WORDS : MAXUC;
    localparam int unsigned CW    = $clog2(CLR_N) + 1;

    localparam int unsigned FSH = 31 + $clog2(gmrf_pkg::FRAME_US);
    localparam int unsigned ESH = 31 + EPW;
    localparam int unsigned PSH = 31 + PPW;
    localparam longint unsigned M_VBL = (64'd1 << FSH) / 64'(gmrf_pkg::FRAME_US);
    localparam longint unsigned M_EWP = (64'd1 << ESH) / 64'(ENGINE_UCODE_WORDS);
    localparam longint unsigned M_PP  = (64'd1 << PSH) / 64'(PREFETCH_UCODE_WORDS);
    localparam longint unsigned K16   = (64'd1 << 16) % 64'(gmrf_pkg::FRAME_US);
    localparam longint unsigned K32   = (64'd1 << 32) % 64'(gmrf_pkg::FRAME_US);
    localparam longint unsigned K48   = (64'd1 << 48) % 64'(gmrf_pkg::FRAME_US);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_C1   = 3'd3;
    localparam logic [2:0] S_C2   = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    localparam logic [1:0] D_VBL = 2'd0;
    localparam logic [1:0] D_EWP = 2'd1;
    localparam logic [1:0] D_ERP = 2'd2;
    localparam logic [1:0] D_PP  = 2'd3;

    localparam logic DIV_LAST = 1'b1;

    logic [31:0] rf_mem [REG_WORDS];
    logic [31:0] em_mem [ENGINE_UCODE_WORDS];
    logic [31:0] pm_mem [PREFETCH_UCODE_WORDS];
    logic [31:0] rf_q_reg, em_q_reg, pm_q_reg;

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [2:0]     rev_reg;
    logic [2:0]     seed_rev_reg, seed_rev_next;
    logic [EPW-1:0] ewp_reg, ewp_next, erp_reg, erp_next;
    logic [PPW-1:0] pp_reg, pp_next;
    logic [31:0]    resp_reg, resp_next;
    logic           out_valid_reg;
    logic [31:0]    read_data_reg;
    logic [31:0]    div_num_reg, div_num_next;
    logic [31:0]    div_q_reg, div_q_next;
    logic           div_cnt_reg, div_cnt_next;
    logic [1:0]     div_sel_reg, div_sel_next;

    logic [1:0]     kind_reg;
    logic [12:0]    idx_reg;
    logic [31:0]    wdata_reg;
    logic [62:0]    time_reg;

    logic           rf_we, rf_re, em_we, em_re, pm_we, pm_re;
    logic [AW-1:0]  rf_waddr, rf_raddr;
    logic [31:0]    rf_wdata, em_wdata, pm_wdata;
    logic [EPW-1:0] em_waddr;
    logic [PPW-1:0] pm_waddr;

    logic           accept, in_rng;
    logic [31:0]    fold_sum, div_d, div_m, div_q, div_r0, div_rem;
    logic [63:0]    div_prod;
    logic [31:0]    pwv;
    logic [EPW-1:0] ewp_inc, erp_inc;
    logic [PPW-1:0] pp_inc;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign in_rng    = (15'(idx_reg) < 15'(REG_WORDS));

    assign ewp_inc = (ewp_reg == EPW'(ENGINE_UCODE_WORDS - 1)) ? '0 : ewp_reg + 1'b1;
    assign erp_inc = (erp_reg == EPW'(ENGINE_UCODE_WORDS - 1)) ? '0 : erp_reg + 1'b1;
    assign pp_inc  = (pp_reg == PPW'(PREFETCH_UCODE_WORDS - 1)) ? '0 : pp_reg + 1'b1;

    // The time is folded in 16-bit chunks (the top one 15 bits), each weighted
    // by its power of two modulo the frame length: sum congruent, below 2^32.
    assign fold_sum = 32'(time_reg[15:0])
                    + 32'(time_reg[31:16]) * 32'(K16)
                    + 32'(time_reg[47:32]) * 32'(K32)
                    + 32'(time_reg[62:48]) * 32'(K48);

    always_comb
    begin
        case (div_sel_reg)
            D_VBL:
            begin
                div_d = 32'(gmrf_pkg::FRAME_US);
                div_m = 32'(M_VBL);
            end
            D_PP:
            begin
                div_d = 32'(PREFETCH_UCODE_WORDS);
                div_m = 32'(M_PP);
            end
            default:
            begin
                div_d = 32'(ENGINE_UCODE_WORDS);
                div_m = 32'(M_EWP);
            end
        endcase
        div_prod = 64'(div_num_reg) * 64'(div_m);
        case (div_sel_reg)
            D_VBL:   div_q = 32'(div_prod >> FSH);
            D_PP:    div_q = 32'(div_prod >> PSH);
            default: div_q = 32'(div_prod >> ESH);
        endcase
        div_r0  = div_num_reg - div_q_reg * div_d;
        div_rem = (div_r0 >= div_d) ? div_r0 - div_d : div_r0;
    end

    always_comb
    begin
        pwv = wdata_reg;
        unique case (idx_reg)
            gmrf_pkg::R_MH_STATUS:    pwv = wdata_reg | gmrf_pkg::MH_READY;
            gmrf_pkg::R_COHER_STATUS: pwv = wdata_reg | gmrf_pkg::COHER_BUSY;
            gmrf_pkg::R_EDRAM_TIMING:
            begin
                if ((wdata_reg & gmrf_pkg::EDRAM_BITS) < gmrf_pkg::EDRAM_LIMIT)
                begin
                    pwv = wdata_reg | gmrf_pkg::EDRAM_BITS;
                end
            end
            gmrf_pkg::R_RBBM_CNTL, gmrf_pkg::R_LUT_AUTOFILL:
            begin
                if (wdata_reg == gmrf_pkg::TRIG_LOW || wdata_reg == gmrf_pkg::TRIG_HIGH)
                begin
                    pwv = gmrf_pkg::TRIG_DONE;
                end
            end
            default: pwv = wdata_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        seed_rev_next = seed_rev_reg;
        ewp_next      = ewp_reg;
        erp_next      = erp_reg;
        pp_next       = pp_reg;
        resp_next     = resp_reg;
        div_num_next  = div_num_reg;
        div_q_next    = div_q_reg;
        div_cnt_next  = div_cnt_reg;
        div_sel_next  = div_sel_reg;
        rf_we = 1'b0; rf_waddr = AW'(idx_reg); rf_wdata = '0;
        rf_re = 1'b0; rf_raddr = AW'(reg_index);
        em_we = 1'b0; em_waddr = ewp_reg; em_wdata = wdata_reg; em_re = 1'b0;
        pm_we = 1'b0; pm_waddr = pp_reg;  pm_wdata = wdata_reg; pm_re = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rf_re = 1'b1;
                    em_re = 1'b1;
                    pm_re = 1'b1;
                    if (kind == gmrf_pkg::KIND_REINIT)
                    begin
                        state_next    = S_CLR;
                        clr_cnt_next  = '0;
                        seed_rev_next = rev_reg;
                        ewp_next      = '0;
                        erp_next      = '0;
                        pp_next       = '0;
                    end
                    else if (kind == gmrf_pkg::KIND_READ || kind == gmrf_pkg::KIND_WRITE)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                div_num_next = wdata_reg;
                div_cnt_next = 1'b0;
                if (kind_reg == gmrf_pkg::KIND_READ)
                begin
                    state_next = S_RESP;
                    resp_next  = rf_q_reg;
                    if (!in_rng)
                    begin
                        resp_next = '0;
                    end
                    else
                    begin
                        unique case (idx_reg)
                            gmrf_pkg::R_BUS_STATUS:
                            begin
                                resp_next = (rf_q_reg | gmrf_pkg::BUS_SET) & ~gmrf_pkg::BUS_CLR;
                                rf_we = 1'b1;
                            end
                            gmrf_pkg::R_MH_STATUS:
                            begin
                                resp_next = rf_q_reg | gmrf_pkg::MH_READY;
                                rf_we = 1'b1;
                            end
                            gmrf_pkg::R_ME_STATUS: resp_next = '0;
                            gmrf_pkg::R_ME_DATA:
                            begin
                                resp_next = em_q_reg;
                                erp_next  = erp_inc;
                            end
                            gmrf_pkg::R_PFP_DATA:
                            begin
                                resp_next = pm_q_reg;
                                pp_next   = pp_inc;
                            end
                            gmrf_pkg::R_COHER_STATUS:
                            begin
                                resp_next = rf_q_reg & ~gmrf_pkg::COHER_BUSY;
                                rf_we = 1'b1;
                            end
                            gmrf_pkg::R_LUT_AUTOFILL:
                            begin
                                if (rf_q_reg == gmrf_pkg::TRIG_LOW ||
                                    rf_q_reg == gmrf_pkg::TRIG_HIGH)
                                begin
                                    resp_next = gmrf_pkg::TRIG_DONE;
                                    rf_we = 1'b1;
                                end
                            end
                            gmrf_pkg::R_VBLANK_STATUS:
                            begin
                                state_next   = S_DIV;
                                div_num_next = fold_sum;
                                div_sel_next = D_VBL;
                            end
                            default: resp_next = rf_q_reg;
                        endcase
                        rf_wdata = resp_next;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                    if (in_rng)
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = pwv;
                        unique case (idx_reg)
                            gmrf_pkg::R_SOFT_RESET:
                            begin
                                if (wdata_reg == '0)
                                begin
                                    state_next = S_C1;
                                end
                            end
                            gmrf_pkg::R_INT_ACK:
                            begin
                                rf_re = 1'b1;
                                rf_raddr = AW'(gmrf_pkg::R_INT_STATUS);
                                state_next = S_MOD;
                            end
                            gmrf_pkg::R_CRTC_CONTROL:
                            begin
                                if ((wdata_reg & gmrf_pkg::CRTC_VSYNC_EN) != '0)
                                begin
                                    rf_re = 1'b1;
                                    rf_raddr = AW'(gmrf_pkg::R_MH_STATUS);
                                    state_next = S_MOD;
                                end
                            end
                            gmrf_pkg::R_ANA_DATA:
                            begin
                                rf_re = 1'b1;
                                rf_raddr = AW'(gmrf_pkg::R_ANA_ADDR);
                                state_next = S_MOD;
                            end
                            gmrf_pkg::R_ME_WADDR:
                            begin
                                div_sel_next = D_EWP;
                                state_next = S_DIV;
                            end
                            gmrf_pkg::R_ME_RADDR:
                            begin
                                div_sel_next = D_ERP;
                                state_next = S_DIV;
                            end
                            gmrf_pkg::R_PFP_ADDR:
                            begin
                                div_sel_next = D_PP;
                                state_next = S_DIV;
                            end
                            gmrf_pkg::R_ME_DATA:
                            begin
                                em_we = 1'b1;
                                ewp_next = ewp_inc;
                            end
                            gmrf_pkg::R_PFP_DATA:
                            begin
                                pm_we = 1'b1;
                                pp_next = pp_inc;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_MOD:
            begin
                rf_we = 1'b1;
                state_next = S_IDLE;
                unique case (idx_reg)
                    gmrf_pkg::R_INT_ACK:
                    begin
                        rf_waddr = AW'(gmrf_pkg::R_INT_STATUS);
                        rf_wdata = rf_q_reg & ~wdata_reg;
                    end
                    gmrf_pkg::R_CRTC_CONTROL:
                    begin
                        rf_waddr = AW'(gmrf_pkg::R_MH_STATUS);
                        rf_wdata = rf_q_reg | gmrf_pkg::MH_VSYNC | gmrf_pkg::MH_READY;
                    end
                    default:
                    begin
                        rf_waddr = AW'(gmrf_pkg::R_ANA_ADDR);
                        rf_wdata = rf_q_reg ^ 32'd1;
                    end
                endcase
            end
            S_C1:
            begin
                rf_we = 1'b1;
                rf_waddr = AW'(gmrf_pkg::R_CONFIG_CNTL);
                rf_wdata = gmrf_pkg::CONFIG_DEFAULT;
                state_next = S_C2;
            end
            S_C2:
            begin
                rf_we = 1'b1;
                rf_waddr = AW'(gmrf_pkg::R_BUS_STATUS);
                rf_wdata = gmrf_pkg::BUS_DEFAULT;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                div_cnt_next = DIV_LAST;
                if (div_cnt_reg != DIV_LAST)
                begin
                    div_q_next = div_q;
                end
                else
                begin
                    state_next = S_IDLE;
                    case (div_sel_reg)
                        D_VBL:
                        begin
                            resp_next = (div_rem < 32'(gmrf_pkg::VBLANK_US))
                                        ? gmrf_pkg::VBLANK_ACTIVE : '0;
                            state_next = S_RESP;
                        end
                        D_EWP:   ewp_next = div_rem[EPW-1:0];
                        D_ERP:   erp_next = div_rem[EPW-1:0];
                        default: pp_next  = div_rem[PPW-1:0];
                    endcase
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                rf_we    = (clr_cnt_reg < CW'(REG_WORDS));
                rf_waddr = clr_cnt_reg[AW-1:0];
                rf_wdata = (clr_cnt_reg < CW'(8192))
                           ? gmrf_pkg::seed_value(clr_cnt_reg[12:0], seed_rev_reg) : '0;
                em_we    = (clr_cnt_reg < CW'(ENGINE_UCODE_WORDS));
                em_waddr = clr_cnt_reg[EPW-1:0];
                em_wdata = '0;
                pm_we    = (clr_cnt_reg < CW'(PREFETCH_UCODE_WORDS));
                pm_waddr = clr_cnt_reg[PPW-1:0];
                pm_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (rf_re)
        begin
            rf_q_reg <= rf_mem[rf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            em_mem[em_waddr] <= em_wdata;
        end
        if (em_re)
        begin
            em_q_reg <= em_mem[erp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re)
        begin
            pm_q_reg <= pm_mem[pp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            idx_reg   <= reg_index;
            wdata_reg <= write_data;
            time_reg  <= time_us;
        end
        resp_reg    <= resp_next;
        div_num_reg <= div_num_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        div_sel_reg <= div_sel_next;
        if (state_reg == S_RESP && (!out_valid_reg || !out_stall))
        begin
            read_data_reg <= resp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rev_reg       <= gmrf_pkg::REV_RESET;
            seed_rev_reg  <= gmrf_pkg::REV_RESET;
            ewp_reg       <= '0;
            erp_reg       <= '0;
            pp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            seed_rev_reg <= seed_rev_next;
            ewp_reg      <= ewp_next;
            erp_reg      <= erp_next;
            pp_reg       <= pp_next;
            if (cfg_write_en)
            begin
                rev_reg <= cfg_write_data;
            end
            if (state_reg == S_RESP && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `GMRF_ASSERT_NEXT(a_out_only_from_resp, !out_valid_reg && state_reg != S_RESP, !out_valid_reg)
    `GMRF_ASSERT_IMP(a_clr_bounded, state_reg == S_CLR, clr_cnt_reg < CW'(CLR_N))
    `GMRF_ASSERT_NEXT(a_div_bounded, state_reg == S_DIV && div_cnt_reg == DIV_LAST, state_reg != S_DIV)
    `GMRF_ASSERT_NEXT(a_access_exec, accept && (kind == gmrf_pkg::KIND_READ || kind == gmrf_pkg::KIND_WRITE), state_reg == S_EXEC)

endmodule

`default_nettype wire
